// ===== hdl/rmf_pkg.sv =====
// rmf_pkg: shared types of the running median filter
`timescale 1ns / 1ps

package rmf_pkg;

  localparam int SampleWidth = 16;
  localparam int FillWidth   = 4;

  typedef logic signed [SampleWidth-1:0] sample_t;
  typedef logic [FillWidth-1:0]          fill_t;

endpackage

// ===== hdl/rmf_in_if.sv =====
// rmf_in_if: sample channel with valid/ready handshake
`timescale 1ns / 1ps

interface rmf_in_if;
  logic             valid;
  logic             ready;
  rmf_pkg::sample_t sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

// ===== hdl/rmf_out_if.sv =====
// rmf_out_if: result channel with valid/ready handshake
`timescale 1ns / 1ps

interface rmf_out_if;
  logic             valid;
  logic             ready;
  rmf_pkg::sample_t median;
  rmf_pkg::fill_t   fill_count;

  modport source (output valid, output median, output fill_count, input ready);
  modport sink (input valid, input median, input fill_count, output ready);
endinterface

// ===== hdl/rmf_ram.sv =====
// rmf_ram: generic single write port ram with registered read
`timescale 1ns / 1ps

module rmf_ram #(
  parameter int Width = 16,
  parameter int Depth = 15
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                      wdata_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                      rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== hdl/running_median_filter.sv =====
// running_median_filter: sliding window median over a double heap kept in two rams
//
//   channel  dir  handshake     payload
//   in_i     in   valid/ready   sample (signed 16)
//   out_o    out  valid/ready   median (signed 16), fill_count (4)
//
// an item is first written into the ring; then each heap level swapped, the compare
// that ends a sift and each child choice on the way down read two heap entries, and
// the median readout reads one entry (odd count) or two (even count)
// every heap access is a slot-map read followed by a sample-ram read (one port each)
// reset is asynchronous; the slot map reads its fill pattern until each entry is written
// a waiting result sits in the output register while the next sample is taken
`timescale 1ns / 1ps

module running_median_filter #(
  parameter int WINDOW = 15
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  rmf_in_if.sink          in_i,
  rmf_out_if.source       out_o
);

  localparam int RW  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CW  = $clog2(WINDOW + 1);
  localparam int SW  = $clog2(WINDOW + 1) + 2;
  localparam int VW  = rmf_pkg::SampleWidth;
  localparam int RMW = SW + VW;
  localparam int OFS = WINDOW / 2;

  localparam logic signed [SW-1:0] S_ZERO = '0;
  localparam logic signed [SW-1:0] S_ONE  = SW'(1);
  localparam logic signed [SW-1:0] S_MONE = -S_ONE;
  localparam logic signed [SW-1:0] OFS_S  = SW'(OFS);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_INS  = 4'd1;
  localparam logic [3:0] ST_HEAD = 4'd2;
  localparam logic [3:0] ST_PREP = 4'd3;
  localparam logic [3:0] ST_FA0  = 4'd4;
  localparam logic [3:0] ST_FA1  = 4'd5;
  localparam logic [3:0] ST_FA2  = 4'd6;
  localparam logic [3:0] ST_FB0  = 4'd7;
  localparam logic [3:0] ST_FB1  = 4'd8;
  localparam logic [3:0] ST_FB2  = 4'd9;
  localparam logic [3:0] ST_EVAL = 4'd10;
  localparam logic [3:0] ST_SW2  = 4'd11;
  localparam logic [3:0] ST_FIN  = 4'd12;

  localparam logic [1:0] K_MIN_DOWN = 2'd0;
  localparam logic [1:0] K_MAX_DOWN = 2'd1;
  localparam logic [1:0] K_MIN_UP   = 2'd2;
  localparam logic [1:0] K_MAX_UP   = 2'd3;

  localparam logic [1:0] OP_CHOOSE = 2'd0;
  localparam logic [1:0] OP_SWAP   = 2'd1;
  localparam logic [1:0] OP_MED    = 2'd2;

  localparam logic [1:0] PD_NONE     = 2'd0;
  localparam logic [1:0] PD_UP_CHAIN = 2'd1;
  localparam logic [1:0] PD_THEN_MIN = 2'd2;

  function automatic logic [RW-1:0] slot_idx(input logic signed [SW-1:0] s);
    logic [SW-1:0] t;
    t = s + OFS_S;
    return t[RW-1:0];
  endfunction

  function automatic logic signed [SW-1:0] half(input logic signed [SW-1:0] s);
    logic signed [SW-1:0] t;
    t = s + SW'({1'b0, s[SW-1]});
    return t >>> 1;
  endfunction

  function automatic logic signed [SW-1:0] fill_slot(input logic [RW-1:0] k);
    logic [SW-1:0] h;
    h = (SW'(k) + SW'(1)) >> 1;
    return k[0] ? -signed'(h) : signed'(h);
  endfunction

  function automatic logic [RW-1:0] fill_ring(input logic [RW-1:0] x);
    logic signed [SW-1:0] s;
    logic signed [SW-1:0] r;
    s = signed'(SW'(x)) - OFS_S;
    if (s > S_ZERO) begin
      r = s <<< 1;
    end else if (s < S_ZERO) begin
      r = -(s <<< 1) - S_ONE;
    end else begin
      r = S_ZERO;
    end
    return r[RW-1:0];
  endfunction

  logic [3:0]             state_q, state_d;
  logic [CW-1:0]          held_q, held_d;
  logic [RW-1:0]          wp_q, wp_d;
  rmf_pkg::sample_t       samp_q, samp_d;
  logic signed [SW-1:0]   i_q, i_d, a_q, a_d, b_q, b_d;
  logic [RW-1:0]          ra_q, ra_d, rb_q, rb_d;
  rmf_pkg::sample_t       va_q, va_d, vb_q, vb_d;
  logic [1:0]             kind_q, kind_d, op_q, op_d, pend_q, pend_d;
  logic [RW-1:0]          hraddr_q;
  logic [WINDOW-1:0]      hvalid_q, hvalid_d;
  logic                   out_valid_q, out_valid_d;
  rmf_pkg::sample_t       out_med_q, out_med_d;
  rmf_pkg::fill_t         out_fill_q, out_fill_d;

  logic                   h_we, r_we;
  logic [RW-1:0]          h_waddr, h_wdata, h_raddr, h_rdata, h_eff;
  logic [RW-1:0]          r_waddr, r_raddr;
  logic [RMW-1:0]         r_wdata, r_rdata;
  logic signed [SW-1:0]   r_slot;
  rmf_pkg::sample_t       r_val;
  logic signed [SW-1:0]   held_s, cmin, cmax, p;
  logic                   fresh, lt;
  logic signed [VW:0]     sum;

  rmf_ram #(.Width(RW), .Depth(WINDOW)) u_heap_ram (
    .clk_i   (clk_i),
    .we_i    (h_we),
    .waddr_i (h_waddr),
    .wdata_i (h_wdata),
    .raddr_i (h_raddr),
    .rdata_o (h_rdata)
  );

  rmf_ram #(.Width(RMW), .Depth(WINDOW)) u_ring_ram (
    .clk_i   (clk_i),
    .we_i    (r_we),
    .waddr_i (r_waddr),
    .wdata_i (r_wdata),
    .raddr_i (r_raddr),
    .rdata_o (r_rdata)
  );

  assign h_eff  = hvalid_q[hraddr_q] ? h_rdata : fill_ring(hraddr_q);
  assign r_slot = signed'(r_rdata[RMW-1:VW]);
  assign r_val  = signed'(r_rdata[VW-1:0]);
  assign held_s = signed'(SW'(held_q));
  assign cmin   = (held_s - S_ONE) >>> 1;
  assign cmax   = held_s >>> 1;
  assign fresh  = held_q < CW'(WINDOW);
  assign p      = fresh ? fill_slot(wp_q) : r_slot;
  assign lt     = va_q < vb_q;
  assign sum    = {va_q[VW-1], va_q} + {vb_q[VW-1], vb_q};

  assign in_i.ready       = (state_q == ST_IDLE);
  assign out_o.valid      = out_valid_q;
  assign out_o.median     = out_med_q;
  assign out_o.fill_count = out_fill_q;

  always_comb begin
    state_d  = state_q;
    held_d   = held_q;
    wp_d     = wp_q;
    samp_d   = samp_q;
    i_d      = i_q;
    a_d      = a_q;
    b_d      = b_q;
    ra_d     = ra_q;
    rb_d     = rb_q;
    va_d     = va_q;
    vb_d     = vb_q;
    kind_d   = kind_q;
    op_d     = op_q;
    pend_d   = pend_q;
    hvalid_d = hvalid_q;
    out_med_d   = out_med_q;
    out_fill_d  = out_fill_q;
    out_valid_d = out_valid_q && !out_o.ready;
    h_we     = 1'b0;
    h_waddr  = '0;
    h_wdata  = '0;
    h_raddr  = slot_idx(a_q);
    r_we     = 1'b0;
    r_waddr  = '0;
    r_wdata  = '0;
    r_raddr  = wp_q;

    case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          samp_d  = in_i.sample;
          state_d = ST_INS;
        end
      end
      ST_INS: begin
        r_we    = 1'b1;
        r_waddr = wp_q;
        r_wdata = {p, samp_q};
        wp_d    = (wp_q == RW'(WINDOW - 1)) ? '0 : wp_q + RW'(1);
        if (fresh) begin
          held_d = held_q + CW'(1);
        end
        if (p > S_ZERO) begin
          if (!fresh && r_val < samp_q) begin
            kind_d = K_MIN_DOWN;
            i_d    = p <<< 1;
            pend_d = PD_NONE;
          end else begin
            kind_d = K_MIN_UP;
            i_d    = p;
            pend_d = PD_UP_CHAIN;
          end
        end else if (p < S_ZERO) begin
          if (!fresh && samp_q < r_val) begin
            kind_d = K_MAX_DOWN;
            i_d    = p <<< 1;
            pend_d = PD_NONE;
          end else begin
            kind_d = K_MAX_UP;
            i_d    = p;
            pend_d = PD_UP_CHAIN;
          end
        end else begin
          kind_d = K_MAX_DOWN;
          i_d    = S_MONE;
          pend_d = PD_THEN_MIN;
        end
        state_d = ST_HEAD;
      end
      ST_HEAD: begin
        state_d = ST_PREP;
        case (kind_q)
          K_MIN_DOWN: begin
            if (i_q > cmin) begin
              state_d = ST_FIN;
            end else if (i_q > S_ONE && i_q < cmin) begin
              a_d     = i_q + S_ONE;
              b_d     = i_q;
              op_d    = OP_CHOOSE;
              state_d = ST_FA0;
            end
          end
          K_MAX_DOWN: begin
            if (i_q < -cmax) begin
              state_d = ST_FIN;
            end else if (i_q < S_MONE && i_q > -cmax) begin
              a_d     = i_q;
              b_d     = i_q - S_ONE;
              op_d    = OP_CHOOSE;
              state_d = ST_FA0;
            end
          end
          K_MIN_UP: begin
            if (!(i_q > S_ZERO)) begin
              state_d = ST_FIN;
            end
          end
          default: begin
            if (!(i_q < S_ZERO)) begin
              state_d = ST_FIN;
            end
          end
        endcase
      end
      ST_PREP: begin
        if (kind_q == K_MIN_DOWN || kind_q == K_MIN_UP) begin
          a_d = i_q;
          b_d = half(i_q);
        end else begin
          a_d = half(i_q);
          b_d = i_q;
        end
        op_d    = OP_SWAP;
        state_d = ST_FA0;
      end
      ST_FA0: begin
        h_raddr = slot_idx(a_q);
        state_d = ST_FA1;
      end
      ST_FA1: begin
        ra_d    = h_eff;
        r_raddr = h_eff;
        state_d = ST_FA2;
      end
      ST_FA2: begin
        va_d    = r_val;
        state_d = (op_q == OP_MED && held_q[0]) ? ST_EVAL : ST_FB0;
      end
      ST_FB0: begin
        h_raddr = slot_idx(b_q);
        state_d = ST_FB1;
      end
      ST_FB1: begin
        rb_d    = h_eff;
        r_raddr = h_eff;
        state_d = ST_FB2;
      end
      ST_FB2: begin
        vb_d    = r_val;
        state_d = ST_EVAL;
      end
      ST_EVAL: begin
        case (op_q)
          OP_CHOOSE: begin
            if (lt) begin
              i_d = (kind_q == K_MIN_DOWN) ? a_q : b_q;
            end
            state_d = ST_PREP;
          end
          OP_SWAP: begin
            if (lt) begin
              h_we    = 1'b1;
              h_waddr = slot_idx(a_q);
              h_wdata = rb_q;
              hvalid_d[slot_idx(a_q)] = 1'b1;
              r_we    = 1'b1;
              r_waddr = rb_q;
              r_wdata = {a_q, vb_q};
              state_d = ST_SW2;
            end else begin
              state_d = ST_FIN;
            end
          end
          default: begin
            if (!out_valid_q || out_o.ready) begin
              out_valid_d = 1'b1;
              out_med_d   = held_q[0] ? va_q : sum[VW:1];
              out_fill_d  = rmf_pkg::FillWidth'(held_q);
              state_d     = ST_IDLE;
            end
          end
        endcase
      end
      ST_SW2: begin
        h_we    = 1'b1;
        h_waddr = slot_idx(b_q);
        h_wdata = ra_q;
        hvalid_d[slot_idx(b_q)] = 1'b1;
        r_we    = 1'b1;
        r_waddr = ra_q;
        r_wdata = {b_q, va_q};
        i_d     = (kind_q == K_MIN_DOWN || kind_q == K_MAX_DOWN) ? (i_q <<< 1) : half(i_q);
        state_d = ST_HEAD;
      end
      ST_FIN: begin
        pend_d = PD_NONE;
        if (pend_q == PD_UP_CHAIN && i_q == S_ZERO) begin
          kind_d  = (kind_q == K_MIN_UP) ? K_MAX_DOWN : K_MIN_DOWN;
          i_d     = (kind_q == K_MIN_UP) ? S_MONE : S_ONE;
          state_d = ST_HEAD;
        end else if (pend_q == PD_THEN_MIN) begin
          kind_d  = K_MIN_DOWN;
          i_d     = S_ONE;
          state_d = ST_HEAD;
        end else begin
          a_d     = S_ZERO;
          b_d     = S_MONE;
          op_d    = OP_MED;
          state_d = ST_FA0;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      held_q      <= '0;
      wp_q        <= '0;
      kind_q      <= K_MIN_DOWN;
      op_q        <= OP_CHOOSE;
      pend_q      <= PD_NONE;
      hvalid_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      held_q      <= held_d;
      wp_q        <= wp_d;
      kind_q      <= kind_d;
      op_q        <= op_d;
      pend_q      <= pend_d;
      hvalid_q    <= hvalid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    samp_q     <= samp_d;
    i_q        <= i_d;
    a_q        <= a_d;
    b_q        <= b_d;
    ra_q       <= ra_d;
    rb_q       <= rb_d;
    va_q       <= va_d;
    vb_q       <= vb_d;
    hraddr_q   <= h_raddr;
    out_med_q  <= out_med_d;
    out_fill_q <= out_fill_d;
  end

  a_held_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q <= CW'(WINDOW))
    else $error("held count beyond window");

  a_wp_tracks_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (held_q < CW'(WINDOW)) |-> (CW'(wp_q) == held_q))
    else $error("write pointer out of step with fill count");

  a_transfer_starts_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> (state_q == ST_INS))
    else $error("input transfer did not start an insert");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready) |=> (out_valid_q && $stable(out_med_q)))
    else $error("pending result lost");

endmodule
